FILE: sv/lkt_pkg.sv
// Package for the LRU key tracker: mode and status codes and the sequencer state type.
// No dependencies.
package lkt_pkg;

	typedef enum logic [1:0] {
		MODE_TOUCH  = 2'd0,
		MODE_POP    = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_OUT
	} state_t;

	localparam int unsigned MODE_BITS   = 2;
	localparam int unsigned STATUS_BITS = 2;
	localparam int unsigned COUNT_BITS  = 7;
	localparam int unsigned KEY_W       = 32;

endpackage

FILE: sv/lkt_if.sv
// Valid/ready channel interfaces for the LRU key tracker.
// Depends on lkt_pkg for field widths.
interface lkt_req_if;
	logic                               valid;
	logic                               ready;
	logic [lkt_pkg::MODE_BITS-1:0]      mode;
	logic [lkt_pkg::KEY_W-1:0]          key;
	modport source (output valid, mode, key, input ready);
	modport sink   (input valid, mode, key, output ready);
endinterface

interface lkt_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [lkt_pkg::STATUS_BITS-1:0]    status;
	logic                               hit;
	logic [lkt_pkg::KEY_W-1:0]          popped_key;
	logic [lkt_pkg::COUNT_BITS-1:0]     used_count;
	modport source (output valid, status, hit, popped_key, used_count, input ready);
	modport sink   (input valid, status, hit, popped_key, used_count, output ready);
endinterface

FILE: sv/lru_key_tracker_core.sv
// LRU key tracker: key store in one synchronous memory and a scan/shift sequencer.
// Depends on lkt_pkg and the interfaces in lkt_if.sv.
//
// Usage: requests arrive on req (mode, key); each produces exactly one response on
// rsp (status, hit, popped_key, used_count). Position 0 of the memory holds the
// most recent key, position count-1 the least recent one.
// A touch or remove first scans positions 0..count-1, one memory read per cycle,
// to find the key, then moves the entries between the hit position and the front
// (touch) or closes the gap toward the tail (remove), one entry per cycle through
// the single read port. A pop reads the tail entry; a clear only zeroes the count.
// A touch that misses inserts the key at the front and moves every entry one older,
// unless the store is full; a clear or a pop of an empty store reads no memory.
// One request is in flight at a time; req.ready is low while it is worked on.
// The response waits in an output register until rsp.ready is high; a stalled
// receiver holds the block, and no state is lost. The next request is accepted
// in the cycle after the response transfer.
// Reset empties the store at once (count zero); memory contents need no clearing.
module lru_key_tracker_core #(
	parameter int ENTRIES  = 64,
	parameter int KEY_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	lkt_req_if.sink         req,
	lkt_rsp_if.source       rsp
);
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	// Key memory.
	logic [KEY_BITS-1:0] mem [ENTRIES];
	logic [AW-1:0]       rd_addr, wr_addr;
	logic                wr_en;
	logic [KEY_BITS-1:0] wr_data, rd_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

	// Sequencer registers.
	lkt_pkg::state_t     state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       pos_q, pos_d;     // position being read
	logic                rdv_q, rdv_d;     // a read was issued last cycle
	logic [CW-1:0]       rpos_q, rpos_d;   // position of that read
	logic [1:0]          mode_q, mode_d;
	logic [KEY_BITS-1:0] key_q, key_d;
	logic [CW-1:0]       hpos_q, hpos_d;   // hit position
	logic                ovalid_q, ovalid_d;
	logic [1:0]          ostat_q, ostat_d;
	logic                ohit_q, ohit_d;
	logic [KEY_BITS-1:0] opop_q, opop_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lkt_pkg::S_IDLE;
			count_q  <= '0;
			ovalid_q <= 1'b0;
			rdv_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			ovalid_q <= ovalid_d;
			rdv_q    <= rdv_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		rpos_q  <= rpos_d;
		mode_q  <= mode_d;
		key_q   <= key_d;
		hpos_q  <= hpos_d;
		ostat_q <= ostat_d;
		ohit_q  <= ohit_d;
		opop_q  <= opop_d;
	end

	// Next state, memory control and response.
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		pos_d    = pos_q;
		rdv_d    = 1'b0;
		rpos_d   = pos_q;
		mode_d   = mode_q;
		key_d    = key_q;
		hpos_d   = hpos_q;
		ovalid_d = ovalid_q;
		ostat_d  = ostat_q;
		ohit_d   = ohit_q;
		opop_d   = opop_q;
		rd_addr  = pos_q[AW-1:0];
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = key_q;
		req.ready = 1'b0;

		if (ovalid_q && rsp.ready) begin
			ovalid_d = 1'b0;
		end

		case (state_q)
			lkt_pkg::S_IDLE: begin
				req.ready = !ovalid_q;
				if (req.valid && !ovalid_q) begin
					mode_d = req.mode;
					key_d  = KEY_BITS'(req.key);
					pos_d  = '0;
					ohit_d = 1'b0;
					opop_d = '0;
					ostat_d = lkt_pkg::ST_OK;
					case (lkt_pkg::mode_t'(req.mode))
						lkt_pkg::MODE_CLEAR: begin
							count_d = '0;
							state_d = lkt_pkg::S_OUT;
						end
						lkt_pkg::MODE_POP: begin
							if (count_q == '0) begin
								ostat_d = lkt_pkg::ST_EMPTY;
								state_d = lkt_pkg::S_OUT;
							end else begin
								pos_d   = count_q - 1'b1;
								state_d = lkt_pkg::S_SCAN;
							end
						end
						default: begin
							state_d = lkt_pkg::S_SCAN;
						end
					endcase
				end
			end
			lkt_pkg::S_SCAN: begin
				if (mode_q == lkt_pkg::MODE_POP) begin
					if (!rdv_q) begin
						rdv_d = 1'b1;
					end else begin
						opop_d  = rd_data;
						count_d = count_q - 1'b1;
						state_d = lkt_pkg::S_OUT;
					end
				end else if (rdv_q && rd_data == key_q) begin
					// Found at rpos_q.
					ohit_d = 1'b1;
					hpos_d = rpos_q;
					if (mode_q == lkt_pkg::MODE_TOUCH) begin
						// Write key to front, carry front entry older.
						wr_en   = 1'b1;
						wr_addr = '0;
						wr_data = key_q;
						pos_d   = CW'(1);
						if (rpos_q == '0) begin
							state_d = lkt_pkg::S_OUT;
						end else begin
							rd_addr = '0;
							rdv_d   = 1'b1;
							rpos_d  = '0;
							state_d = lkt_pkg::S_SHIFT;
						end
					end else begin
						pos_d = rpos_q + 1'b1;
						if (rpos_q + 1'b1 >= count_q) begin
							count_d = count_q - 1'b1;
							state_d = lkt_pkg::S_OUT;
						end else begin
							rd_addr = AW'(rpos_q + 1'b1);
							rdv_d   = 1'b1;
							rpos_d  = rpos_q + 1'b1;
							state_d = lkt_pkg::S_SHIFT;
						end
					end
				end else if (pos_q < count_q) begin
					// Issue next scan read.
					rdv_d  = 1'b1;
					rpos_d = pos_q;
					pos_d  = pos_q + 1'b1;
				end else if (!rdv_q || pos_q >= count_q) begin
					// Scan finished without a match.
					if (mode_q == lkt_pkg::MODE_REMOVE) begin
						ostat_d = lkt_pkg::ST_ABSENT;
					end else if (count_q >= CW'(ENTRIES)) begin
						ostat_d = lkt_pkg::ST_FULL;
					end else begin
						// Insert: shift entries 0..count-1 one older.
						hpos_d  = count_q;
						count_d = count_q + 1'b1;
						wr_en   = 1'b1;
						wr_addr = '0;
						wr_data = key_q;
						if (count_q != '0) begin
							rd_addr = '0;
							rdv_d   = 1'b1;
							rpos_d  = '0;
							state_d = lkt_pkg::S_SHIFT;
						end
					end
					if (state_d == lkt_pkg::S_SCAN) begin
						state_d = lkt_pkg::S_OUT;
					end
				end
			end
			lkt_pkg::S_SHIFT: begin
				if (mode_q == lkt_pkg::MODE_TOUCH) begin
					// rd_data is the old entry at rpos_q; it moves to rpos_q+1.
					// The read of the next entry lands in the same cycle as the write
					// to it and returns the old contents.
					wr_en   = 1'b1;
					wr_addr = AW'(rpos_q + 1'b1);
					wr_data = rd_data;
					if (rpos_q + 1'b1 >= hpos_q) begin
						state_d = lkt_pkg::S_OUT;
					end else begin
						rd_addr = AW'(rpos_q + 1'b1);
						rdv_d   = 1'b1;
						rpos_d  = rpos_q + 1'b1;
					end
				end else begin
					// Remove: entry at rpos_q moves to rpos_q-1.
					wr_en   = 1'b1;
					wr_addr = AW'(rpos_q - 1'b1);
					wr_data = rd_data;
					if (rpos_q + 1'b1 >= count_q) begin
						count_d = count_q - 1'b1;
						state_d = lkt_pkg::S_OUT;
					end else begin
						rd_addr = AW'(rpos_q + 1'b1);
						rdv_d   = 1'b1;
						rpos_d  = rpos_q + 1'b1;
					end
				end
			end
			lkt_pkg::S_OUT: begin
				ovalid_d = 1'b1;
				state_d  = lkt_pkg::S_IDLE;
			end
			default: begin
				state_d = lkt_pkg::S_IDLE;
			end
		endcase
	end

	// Response register.
	assign rsp.valid      = ovalid_q;
	assign rsp.status     = ostat_q;
	assign rsp.hit        = ohit_q;
	assign rsp.popped_key = lkt_pkg::KEY_W'(opop_q);
	assign rsp.used_count = lkt_pkg::COUNT_BITS'(count_q);

endmodule
